// ===== rtl/wsu_pkg.sv =====
// Types and constants shared by the websocket frame unmasker modules.
`timescale 1ns / 1ps

package wsu_pkg;

  typedef enum logic [2:0] {
    PH_HDR0     = 3'd0,
    PH_HDR1     = 3'd1,
    PH_HDR1_CLS = 3'd2,
    PH_EXTLEN   = 3'd3,
    PH_MASK     = 3'd4,
    PH_PAYLOAD  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_BINARY = 4'h2;

  localparam logic [6:0] LEN_EXT16 = 7'd126;

  localparam logic [3:0] CNT_EXT16 = 4'd2;
  localparam logic [3:0] CNT_EXT64 = 4'd8;
  localparam logic [3:0] CNT_MASK  = 4'd4;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

// ===== rtl/websocket_frame_unmasker.sv =====
// A result is registered and appears on the master side in the cycle after its input byte is taken.
// Throughput: one byte per cycle; the slave side stays ready while the output register
// is empty or is being drained in the same cycle.
// Reset (rst, synchronous): parser returns to the first header byte, clears the halt,
// and the output register is emptied.
`timescale 1ns / 1ps

module websocket_frame_unmasker
  import wsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] payload_byte
  output logic [1:0] m_tuser,   // [1:0] result_kind
  output logic       m_tlast    // last_of_frame
);

  logic    accept;
  result_t res;
  logic    halted;
  kind_t   out_kind;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  wsu_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .res       (res),
    .halted    (halted)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      out_kind <= res.kind;
      m_tdata  <= res.data;
      m_tlast  <= res.last;
    end
  end

  assign m_tuser = out_kind;

`ifndef SYNTHESIS
  a_valid_from_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("result appeared without an accepted transaction");

  a_last_only_on_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser == KIND_DATA))
    else $error("last flag on a non-payload result");

  a_status_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_DATA) |-> (m_tdata == 8'd0 && !m_tlast))
    else $error("status result carries payload bits");

  a_halt_after_stop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_CLOSE || m_tuser == KIND_BAD)) |-> halted)
    else $error("parser not halted after close or unsupported frame");
`endif

endmodule

// ===== rtl/wsu_parser.sv =====
// Header parser, length and mask key capture, and payload unmasking.
`timescale 1ns / 1ps

module wsu_parser
  import wsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  output result_t    res,
  output logic       halted
);

  phase_t      phase, phase_next;
  logic [3:0]  count, count_next;
  logic        opcode_ok, opcode_ok_next;
  logic [63:0] length, length_next;
  logic [31:0] mask_key, mask_key_next;
  logic [63:0] remaining, remaining_next;
  logic [1:0]  mask_pos, mask_pos_next;
  logic        halted_next;

  logic [3:0]  count_dec;
  logic [63:0] remaining_dec;
  logic [7:0]  key_byte;

  assign count_dec     = count - 4'd1;
  assign remaining_dec = remaining - 64'd1;

  always_comb begin
    unique case (mask_pos)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_next     = phase;
    count_next     = count;
    opcode_ok_next = opcode_ok;
    length_next    = length;
    mask_key_next  = mask_key;
    remaining_next = remaining;
    mask_pos_next  = mask_pos;
    halted_next    = halted;
    if (accept && !halted) begin
      unique case (phase)
        PH_HDR0: begin
          opcode_ok_next = data_byte[7] && (data_byte[3:0] == OP_BINARY);
          phase_next     = (data_byte[3:0] == OP_CLOSE) ? PH_HDR1_CLS : PH_HDR1;
          length_next    = '0;
          mask_key_next  = '0;
          mask_pos_next  = '0;
          count_next     = '0;
        end
        PH_HDR1, PH_HDR1_CLS: begin
          if (phase == PH_HDR1_CLS || !opcode_ok || !data_byte[7]) begin
            halted_next = 1'b1;
          end else if (data_byte[6:0] < LEN_EXT16) begin
            length_next = {57'd0, data_byte[6:0]};
            count_next  = CNT_MASK;
            phase_next  = PH_MASK;
          end else begin
            length_next = '0;
            count_next  = (data_byte[6:0] == LEN_EXT16) ? CNT_EXT16 : CNT_EXT64;
            phase_next  = PH_EXTLEN;
          end
        end
        PH_EXTLEN: begin
          length_next = {length[55:0], data_byte};
          count_next  = count_dec;
          if (count_dec == 4'd0) begin
            count_next = CNT_MASK;
            phase_next = PH_MASK;
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], data_byte};
          count_next    = count_dec;
          if (count_dec == 4'd0) begin
            mask_pos_next  = '0;
            remaining_next = length;
            phase_next     = (length == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          mask_pos_next  = mask_pos + 2'd1;
          remaining_next = remaining_dec;
          if (remaining_dec == 64'd0) begin
            phase_next = PH_HDR0;
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase
    end
  end

  // result for the byte at the input
  always_comb begin
    res = '{valid: 1'b0, kind: KIND_DATA, data: 8'd0, last: 1'b0};
    if (!halted) begin
      unique case (phase)
        PH_HDR1, PH_HDR1_CLS: begin
          if (phase == PH_HDR1_CLS) begin
            res.valid = 1'b1;
            res.kind  = KIND_CLOSE;
          end else if (!opcode_ok || !data_byte[7]) begin
            res.valid = 1'b1;
            res.kind  = KIND_BAD;
          end
        end
        PH_MASK: begin
          if (count_dec == 4'd0 && length == 64'd0) begin
            res.valid = 1'b1;
            res.kind  = KIND_EMPTY;
          end
        end
        PH_PAYLOAD: begin
          res.valid = 1'b1;
          res.kind  = KIND_DATA;
          res.data  = data_byte ^ key_byte;
          res.last  = (remaining_dec == 64'd0);
        end
        default: begin
          res.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      count     <= '0;
      opcode_ok <= 1'b0;
      length    <= '0;
      mask_key  <= '0;
      remaining <= '0;
      mask_pos  <= '0;
      halted    <= 1'b0;
    end else begin
      phase     <= phase_next;
      count     <= count_next;
      opcode_ok <= opcode_ok_next;
      length    <= length_next;
      mask_key  <= mask_key_next;
      remaining <= remaining_next;
      mask_pos  <= mask_pos_next;
      halted    <= halted_next;
    end
  end

endmodule

// ===== dv/tb.sv =====
// Testbench for websocket_frame_unmasker: framed byte streams checked against an in-bench parser.
`timescale 1ns / 1ps

module tb;
  import wsu_pkg::*;

  localparam logic [6:0] LEN_EXT64    = 7'd127;
  localparam int         MAX_GAP      = 14;
  localparam int         STREAM_BYTES = 1100;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         REPORT_LIMIT = 10;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } frame_result_t;

  class unmask_scoreboard;
    phase_t        phase;
    logic [3:0]    hdr_left;
    logic          op_ok;
    logic [63:0]   frame_len;
    logic [63:0]   bytes_left;
    logic [31:0]   key;
    logic [1:0]    key_pos;
    logic          halted;
    frame_result_t unmasked_q[$];
    int            mismatches;

    function new();
      phase      = PH_HDR0;
      hdr_left   = '0;
      op_ok      = 1'b0;
      frame_len  = '0;
      bytes_left = '0;
      key        = '0;
      key_pos    = '0;
      halted     = 1'b0;
      mismatches = 0;
    endfunction

    function void push(kind_t kind, logic [7:0] data, logic last);
      frame_result_t r;
      r.kind = kind;
      r.data = data;
      r.last = last;
      unmasked_q.push_back(r);
    endfunction

    function int pending();
      return unmasked_q.size();
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] key_byte;
      if (halted) return;
      case (phase)
        PH_HDR0: begin
          op_ok     = b[7] && (b[3:0] == OP_BINARY);
          phase     = (b[3:0] == OP_CLOSE) ? PH_HDR1_CLS : PH_HDR1;
          frame_len = '0;
          key       = '0;
          key_pos   = '0;
          hdr_left  = '0;
        end
        PH_HDR1, PH_HDR1_CLS: begin
          if (phase == PH_HDR1_CLS) begin
            halted = 1'b1;
            push(KIND_CLOSE, 8'h00, 1'b0);
          end else if (!op_ok || !b[7]) begin
            halted = 1'b1;
            push(KIND_BAD, 8'h00, 1'b0);
          end else if (b[6:0] < LEN_EXT16) begin
            frame_len = {57'd0, b[6:0]};
            hdr_left  = CNT_MASK;
            phase     = PH_MASK;
          end else begin
            frame_len = '0;
            hdr_left  = (b[6:0] == LEN_EXT16) ? CNT_EXT16 : CNT_EXT64;
            phase     = PH_EXTLEN;
          end
        end
        PH_EXTLEN: begin
          frame_len = {frame_len[55:0], b};
          hdr_left  = hdr_left - 4'd1;
          if (hdr_left == 4'd0) begin
            hdr_left = CNT_MASK;
            phase    = PH_MASK;
          end
        end
        PH_MASK: begin
          key      = {key[23:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 4'd0) begin
            key_pos    = '0;
            bytes_left = frame_len;
            if (frame_len == 64'd0) begin
              phase = PH_HDR0;
              push(KIND_EMPTY, 8'h00, 1'b0);
            end else begin
              phase = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          key_byte   = key[8 * (3 - key_pos) +: 8];
          key_pos    = key_pos + 2'd1;
          bytes_left = bytes_left - 64'd1;
          if (bytes_left == 64'd0) phase = PH_HDR0;
          push(KIND_DATA, b ^ key_byte, bytes_left == 64'd0);
        end
        default: phase = PH_HDR0;
      endcase
    endfunction

    function void check_result(kind_t kind, logic [7:0] data, logic last);
      frame_result_t e;
      if (unmasked_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: kind %0d data %02h last %0d", kind, data, last);
        return;
      end
      e = unmasked_q.pop_front();
      if (e.kind !== kind || e.data !== data || e.last !== last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: expected kind %0d data %02h last %0d, got kind %0d data %02h last %0d",
                   e.kind, e.data, e.last, kind, data, last);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;   // [7:0] payload_byte
  logic [1:0] m_tuser;   // [1:0] result_kind
  logic       m_tlast;   // last_of_frame

  unmask_scoreboard sb;
  int cycle_count = 0;
  int bytes_sent  = 0;
  bit send_burst  = 1'b0;
  bit recv_burst  = 1'b0;

  websocket_frame_unmasker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // alternate 00/ff payload when extremes is set, random otherwise
  task automatic send_frame(input logic [7:0] first, input logic [7:0] second,
                            input logic [63:0] len, input logic [31:0] mask,
                            input int body, input bit extremes);
    int i;
    send_byte(first);
    send_byte(second);
    if (second[6:0] == LEN_EXT16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (second[6:0] == LEN_EXT64) begin
      for (i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    end
    for (i = 3; i >= 0; i--) send_byte(mask[8 * i +: 8]);
    for (i = 0; i < body; i++)
      send_byte(extremes ? (i[0] ? 8'hff : 8'h00) : 8'($urandom));
  endtask

  task automatic send_random_frame();
    int          sel;
    logic [63:0] len;
    logic [6:0]  len_code;
    logic [7:0]  first;
    sel   = $urandom_range(0, 99);
    first = {1'b1, 3'($urandom_range(0, 7)), OP_BINARY};
    if (sel < 8) begin
      len = 64'd0;
      len_code = 7'd0;
    end else if (sel < 60) begin
      len = 64'($urandom_range(1, 20));
      len_code = len[6:0];
    end else if (sel < 75) begin
      len = 64'($urandom_range(21, 125));
      len_code = len[6:0];
    end else if (sel < 88) begin
      len = 64'($urandom_range(0, 300));
      len_code = LEN_EXT16;
    end else begin
      len = 64'($urandom_range(0, 60));
      len_code = LEN_EXT64;
    end
    send_frame(first, {1'b1, len_code}, len, $urandom, int'(len), $urandom_range(0, 7) == 0);
  endtask

  initial begin
    int          ending;
    int          i;
    logic [3:0]  op;
    logic [63:0] len;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_frame({1'b1, 3'b000, OP_BINARY}, {1'b1, 7'd0}, 64'd0, $urandom, 0, 1'b0);
    send_frame({1'b1, 3'b111, OP_BINARY}, {1'b1, 7'd2}, 64'd2, 32'hffffffff, 2, 1'b1);
    send_frame({1'b1, 3'b010, OP_BINARY}, {1'b1, LEN_EXT16}, 64'd1, 32'h00000000, 1, 1'b0);

    while (bytes_sent < STREAM_BYTES) send_random_frame();

    // one terminating frame; the halting kinds stop the parser for good
    ending = $urandom_range(0, 4);
    case (ending)
      0: begin
        send_byte({1'($urandom), 3'($urandom), OP_CLOSE});
        send_byte(8'($urandom));
      end
      1: begin
        send_byte({1'b0, 3'($urandom), OP_BINARY});
        send_byte({1'b1, 7'($urandom)});
      end
      2: begin
        send_byte({1'b1, 3'($urandom), OP_BINARY});
        send_byte({1'b0, 7'($urandom)});
      end
      3: begin
        do op = 4'($urandom); while (op == OP_BINARY || op == OP_CLOSE);
        send_byte({1'($urandom), 3'($urandom), op});
        send_byte({1'b1, 7'($urandom)});
      end
      default: begin
        len = {$urandom, $urandom};
        len[63] = 1'b1;
        send_frame({1'b1, 3'($urandom), OP_BINARY}, {1'b1, LEN_EXT64}, len, $urandom, 10, 1'b0);
      end
    endcase
    if (ending < 4) begin
      for (i = 0; i < 8; i++) send_byte(8'($urandom));
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      gap = draw_gap(recv_burst);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(kind_t'(m_tuser), m_tdata, m_tlast);
    end
  end

endmodule
